### rtl/ddc_pkg.sv
// Shared constants, codes and types of the DMA dimension coalescer.
package ddc_pkg;

  // Dimension store depth and the widths that follow from it
  localparam int MAX_RANK  = 8;
  localparam int RED_DEPTH = MAX_RANK + 1;
  localparam int RANK_W    = $clog2(MAX_RANK + 1);
  localparam int IDX_W     = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int RED_IDX_W = $clog2(RED_DEPTH);
  localparam int RED_CNT_W = $clog2(RED_DEPTH + 1);

  // Field widths
  localparam int SIZE_W     = 32;
  localparam int STRIDE_W   = 48;
  localparam int OSIZE_W    = 48;
  localparam int OSTRIDE_W  = 45;
  localparam int EBITS_W    = 7;

  localparam logic [EBITS_W-1:0] EBITS_RESET = EBITS_W'(8);

  // One byte is eight bits
  localparam int BYTE_SHIFT = 3;
  localparam int BYTE_RND   = (1 << BYTE_SHIFT) - 1;

  // Shared multiplier: full operand times one chunk of the other per cycle
  localparam int MUL_CHUNK  = 16;
  localparam int MUL_STEPS  = STRIDE_W / MUL_CHUNK;
  localparam int MUL_STEP_W = $clog2(MUL_STEPS + 1);
  localparam int ACC_W      = 2 * STRIDE_W;

  // Element-width divider: a few quotient bits per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_ITER  = (STRIDE_W + 1 + DIV_BITS - 1) / DIV_BITS;
  localparam int DIVD_W    = DIV_ITER * DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_ITER);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = EBITS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ELEMENT_BITS,
    CFG_CUMULATIVE_MODE
  } ddc_cfg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,   // load dimensions
    S_EXT,    // outer stride = size0 * stride0
    S_RP,     // running product times current size
    S_CMP,    // compactness test: prev * size < stride
    S_TAIL,   // push the leftover outer entry
    S_DLOAD,  // round size, convert stride, start divide
    S_DRUN,   // divide by element width
    S_DFIN,   // write back reduced size
    S_CUM,    // suffix products
    S_EMIT    // one result word per cycle
  } ddc_state_t;

endpackage

### rtl/dma_dimension_coalescer.sv
// Top level of the DMA dimension coalescer: sequencer, stores and shared arithmetic.
//
// Usage: dimensions arrive outermost first, one word per start pulse taken
// while busy is low (in_dim_size, in_dim_stride_bits, in_last_dim). Words
// without in_last_dim are stored and leave busy low. The word
// with in_last_dim raises busy while the view is walked from the innermost
// dimension outward; reduced (size, byte stride) words then leave on the out_
// ports, outermost first, one per cycle, each marked by a one-cycle out_valid.
// out_last marks the final word; an error gives a single word with out_error.
// The last word follows these steps: the outer stride, then the walk (two
// passes through the shared 48x16 multiply unit per dimension), the tail,
// the divide pass for each reduced entry (load, the 4-bit-per-cycle divider,
// write-back), suffix products in cumulative mode, and then the results.
// A load with too many dimensions or a zero element width skips the walk
// and goes straight to its error word.
// Reset (synchronous, rst_n low) empties the dimension store and restores
// element_bits = 8 and cumulative_mode = 0. Results cannot be held off by the
// receiver; write cfg_ only while busy is low and no load is part-way in.
module dma_dimension_coalescer import ddc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // dimension words
  input  logic                  start,
  output logic                  busy,
  input  logic [SIZE_W-1:0]     in_dim_size,
  input  logic [STRIDE_W-1:0]   in_dim_stride_bits,
  input  logic                  in_last_dim,
  // result words
  output logic                  out_valid,
  output logic [OSIZE_W-1:0]    out_size,
  output logic [OSTRIDE_W-1:0]  out_stride_bytes,
  output logic                  out_last,
  output logic                  out_error
);

  localparam int RA_W = STRIDE_W + 1;

  // Configuration registers
  logic [EBITS_W-1:0]    ebits_r;
  logic                  cum_r;

  // Sequencer and control state
  ddc_state_t            state_r, state_nxt;
  logic [RANK_W-1:0]     rank_cnt_r, rank_cnt_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  err_r, err_nxt;
  logic [RANK_W-1:0]     dim_r, dim_nxt;
  logic [RED_CNT_W-1:0]  red_cnt_r, red_cnt_nxt;
  logic [RED_IDX_W-1:0]  red_idx_r, red_idx_nxt;
  logic [MUL_STEP_W-1:0] mul_step_r, mul_step_nxt;
  logic [DIV_CNT_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Datapath registers
  logic [STRIDE_W-1:0]   rp_r, rp_nxt;
  logic [STRIDE_W-1:0]   prev_r, prev_nxt;
  logic [STRIDE_W-1:0]   ext0_r, ext0_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [DIVD_W-1:0]     div_q_r, div_q_nxt;
  logic [EBITS_W-1:0]    div_rem_r, div_rem_nxt;
  logic [OSIZE_W-1:0]    out_size_r, out_size_nxt;
  logic [OSTRIDE_W-1:0]  out_stride_r, out_stride_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_error_r, out_error_nxt;

  // Dimension and reduced stores
  logic [SIZE_W-1:0]     size_mem_r   [MAX_RANK];
  logic [STRIDE_W-1:0]   stride_mem_r [MAX_RANK];
  logic [STRIDE_W-1:0]   red_size_r   [RED_DEPTH];
  logic [STRIDE_W-1:0]   red_stride_r [RED_DEPTH];

  logic                  dim_we;
  logic                  red_size_we, red_stride_we;
  logic [RED_IDX_W-1:0]  red_waddr;
  logic [STRIDE_W-1:0]   red_wsize, red_wstride;

  // Walk operands
  logic [RANK_W-1:0]     dim_m1;
  logic [SIZE_W-1:0]     cur_size;
  logic [STRIDE_W-1:0]   cur_stride;
  logic [STRIDE_W-1:0]   rd_size, rd_stride;

  // Shared multiplier
  logic [STRIDE_W-1:0]          mul_a, mul_b;
  logic [MUL_STEP_W-1:0]        chunk_sel;
  logic [MUL_CHUNK-1:0]         mul_chunk;
  logic [STRIDE_W+MUL_CHUNK-1:0] mul_pp;
  logic                         mul_done;
  logic                         mul_ovf;
  logic [STRIDE_W-1:0]          mul_sat;

  // Divider and rounding
  logic [DIVD_W-1:0]     dv_q;
  logic [EBITS_W-1:0]    dv_rem;
  logic [EBITS_W:0]      dv_t;
  logic [DIVD_W-1:0]     div_q_step;
  logic [EBITS_W-1:0]    div_rem_step;
  logic [RA_W-1:0]       red_a;
  logic [RA_W-1:0]       red_sb;
  logic [DIVD_W-1:0]     fin_v0, fin_v;

  logic                  accept;
  logic                  red_last;

  // Read the stores at the walk position
  assign dim_m1     = dim_r - RANK_W'(1);
  assign cur_size   = (dim_r == rank_cnt_r) ? SIZE_W'(ebits_r)
                                            : size_mem_r[dim_r[IDX_W-1:0]];
  assign cur_stride = (dim_r == '0) ? ext0_r : stride_mem_r[dim_m1[IDX_W-1:0]];
  assign rd_size    = red_size_r[red_idx_r];
  assign rd_stride  = red_stride_r[red_idx_r];
  assign red_last   = (RED_CNT_W'(red_idx_r) + RED_CNT_W'(1)) == red_cnt_r;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Select multiplier operands
  always_comb begin
    case (state_r)
      S_EXT: begin
        mul_a = stride_mem_r[0];
        mul_b = STRIDE_W'(size_mem_r[0]);
      end
      S_RP: begin
        mul_a = rp_r;
        mul_b = STRIDE_W'(cur_size);
      end
      S_CMP: begin
        mul_a = prev_r;
        mul_b = STRIDE_W'(cur_size);
      end
      S_CUM: begin
        mul_a = rp_r;
        mul_b = rd_size;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Take the chunks of the second operand from the top down
  assign chunk_sel = MUL_STEP_W'(MUL_STEPS - 1) - mul_step_r;

  always_comb begin
    mul_chunk = '0;
    for (int k = 0; k < MUL_STEPS; k++) begin
      if (int'(chunk_sel) == k) begin
        mul_chunk = mul_b[k*MUL_CHUNK +: MUL_CHUNK];
      end
    end
  end

  assign mul_pp   = mul_a * mul_chunk;
  assign mul_done = (mul_step_r == MUL_STEP_W'(MUL_STEPS));
  assign mul_ovf  = |acc_r[ACC_W-1:STRIDE_W];
  assign mul_sat  = mul_ovf ? '1 : acc_r[STRIDE_W-1:0];

  // Accumulate partial products, shifting the running sum one chunk up
  always_comb begin
    if (mul_done) begin
      acc_nxt = acc_r;
    end else if (mul_step_r == '0) begin
      acc_nxt = ACC_W'(mul_pp);
    end else begin
      acc_nxt = (acc_r << MUL_CHUNK) + ACC_W'(mul_pp);
    end
  end

  // Restoring divide by the element width, a few quotient bits a cycle
  always_comb begin
    dv_q   = div_q_r;
    dv_rem = div_rem_r;
    dv_t   = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      dv_t = {dv_rem, dv_q[DIVD_W-1]};
      dv_q = {dv_q[DIVD_W-2:0], 1'b0};
      if (dv_t >= {1'b0, ebits_r}) begin
        dv_t    = dv_t - {1'b0, ebits_r};
        dv_q[0] = 1'b1;
      end
      dv_rem = dv_t[EBITS_W-1:0];
    end
    div_q_step   = dv_q;
    div_rem_step = dv_rem;
  end

  // Round size up to a byte boundary; convert stride to bytes
  assign red_a  = ({1'b0, rd_size} + RA_W'(BYTE_RND)) & ~RA_W'(BYTE_RND);
  assign red_sb = ({1'b0, rd_stride} + RA_W'(BYTE_RND)) >> BYTE_SHIFT;

  // Innermost entry goes back to bytes: ceil((q * E) / 8) with q * E = a - rem
  assign fin_v0 = (DIVD_W'(red_a) - DIVD_W'(div_rem_r) + DIVD_W'(BYTE_RND)) >> BYTE_SHIFT;
  assign fin_v  = (red_idx_r == '0) ? fin_v0 : div_q_r;

  // Sequencer: next state, datapath updates and store writes
  always_comb begin
    state_nxt      = state_r;
    rank_cnt_nxt   = rank_cnt_r;
    ovf_nxt        = ovf_r;
    err_nxt        = err_r;
    dim_nxt        = dim_r;
    red_cnt_nxt    = red_cnt_r;
    red_idx_nxt    = red_idx_r;
    mul_step_nxt   = mul_step_r;
    div_cnt_nxt    = div_cnt_r;
    rp_nxt         = rp_r;
    prev_nxt       = prev_r;
    ext0_nxt       = ext0_r;
    div_q_nxt      = div_q_r;
    div_rem_nxt    = div_rem_r;
    out_valid_nxt  = 1'b0;
    out_size_nxt   = out_size_r;
    out_stride_nxt = out_stride_r;
    out_last_nxt   = out_last_r;
    out_error_nxt  = out_error_r;
    dim_we         = 1'b0;
    red_size_we    = 1'b0;
    red_stride_we  = 1'b0;
    red_waddr      = red_cnt_r[RED_IDX_W-1:0];
    red_wsize      = rp_r;
    red_wstride    = cur_stride;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // store the word, or flag one dimension too many
          if (rank_cnt_r < RANK_W'(MAX_RANK)) begin
            dim_we       = 1'b1;
            rank_cnt_nxt = rank_cnt_r + RANK_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_dim) begin
            if (ovf_nxt || ebits_r == '0) begin
              err_nxt   = 1'b1;
              state_nxt = S_EMIT;
            end else begin
              dim_nxt      = rank_cnt_nxt;
              rp_nxt       = STRIDE_W'(1);
              prev_nxt     = STRIDE_W'(1);
              red_cnt_nxt  = '0;
              mul_step_nxt = '0;
              state_nxt    = S_EXT;
            end
          end
        end
      end

      S_EXT: begin
        mul_step_nxt = mul_step_r + MUL_STEP_W'(1);
        if (mul_done) begin
          mul_step_nxt = '0;
          ext0_nxt     = mul_sat;
          err_nxt      = err_r || mul_ovf;
          state_nxt    = S_RP;
        end
      end

      S_RP: begin
        mul_step_nxt = mul_step_r + MUL_STEP_W'(1);
        if (mul_done) begin
          mul_step_nxt = '0;
          rp_nxt       = mul_sat;
          err_nxt      = err_r || mul_ovf;
          state_nxt    = S_CMP;
        end
      end

      S_CMP: begin
        mul_step_nxt = mul_step_r + MUL_STEP_W'(1);
        if (mul_done) begin
          mul_step_nxt = '0;
          // cut where prev * size falls short of the stride
          if (cur_stride != '0 && !mul_ovf && acc_r[STRIDE_W-1:0] < cur_stride) begin
            if (red_cnt_r < RED_CNT_W'(RED_DEPTH)) begin
              red_size_we   = 1'b1;
              red_stride_we = 1'b1;
              red_cnt_nxt   = red_cnt_r + RED_CNT_W'(1);
            end
            rp_nxt = STRIDE_W'(ebits_r);
          end
          prev_nxt = cur_stride;
          if (dim_r == '0) begin
            state_nxt = S_TAIL;
          end else begin
            dim_nxt   = dim_m1;
            state_nxt = S_RP;
          end
        end
      end

      S_TAIL: begin
        if (rp_r > STRIDE_W'(ebits_r) || red_cnt_r == '0) begin
          if (red_cnt_r < RED_CNT_W'(RED_DEPTH)) begin
            red_size_we   = 1'b1;
            red_stride_we = 1'b1;
            red_wstride   = ext0_r;
            red_cnt_nxt   = red_cnt_r + RED_CNT_W'(1);
          end
        end
        red_idx_nxt = '0;
        state_nxt   = S_DLOAD;
      end

      S_DLOAD: begin
        // every stride but the outermost must be whole bytes
        if (!red_last && rd_stride[BYTE_SHIFT-1:0] != '0) begin
          err_nxt = 1'b1;
        end
        if (|red_sb[RA_W-1:OSTRIDE_W]) begin
          err_nxt = 1'b1;
        end
        red_waddr     = red_idx_r;
        red_stride_we = 1'b1;
        red_wstride   = STRIDE_W'(red_sb[OSTRIDE_W-1:0]);
        div_q_nxt     = DIVD_W'(red_a);
        div_rem_nxt   = '0;
        div_cnt_nxt   = '0;
        state_nxt     = S_DRUN;
      end

      S_DRUN: begin
        div_q_nxt   = div_q_step;
        div_rem_nxt = div_rem_step;
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(DIV_ITER - 1)) begin
          state_nxt = S_DFIN;
        end
      end

      S_DFIN: begin
        if (|fin_v[DIVD_W-1:OSIZE_W]) begin
          err_nxt = 1'b1;
        end
        red_waddr   = red_idx_r;
        red_size_we = 1'b1;
        red_wsize   = fin_v[STRIDE_W-1:0];
        if (red_idx_r == '0) begin
          rp_nxt = fin_v[STRIDE_W-1:0];
        end
        if (red_last) begin
          mul_step_nxt = '0;
          if (cum_r && red_cnt_r > RED_CNT_W'(1)) begin
            red_idx_nxt = RED_IDX_W'(1);
            state_nxt   = S_CUM;
          end else begin
            red_idx_nxt = RED_IDX_W'(red_cnt_r - RED_CNT_W'(1));
            state_nxt   = S_EMIT;
          end
        end else begin
          red_idx_nxt = red_idx_r + RED_IDX_W'(1);
          state_nxt   = S_DLOAD;
        end
      end

      S_CUM: begin
        mul_step_nxt = mul_step_r + MUL_STEP_W'(1);
        if (mul_done) begin
          mul_step_nxt = '0;
          err_nxt      = err_r || mul_ovf;
          rp_nxt       = mul_sat;
          red_waddr    = red_idx_r;
          red_size_we  = 1'b1;
          red_wsize    = mul_sat;
          if (red_last) begin
            // drop the outermost pair
            red_idx_nxt = RED_IDX_W'(red_cnt_r - RED_CNT_W'(2));
            state_nxt   = S_EMIT;
          end else begin
            red_idx_nxt = red_idx_r + RED_IDX_W'(1);
          end
        end
      end

      S_EMIT: begin
        out_valid_nxt = 1'b1;
        if (err_r) begin
          out_size_nxt   = '0;
          out_stride_nxt = '0;
          out_last_nxt   = 1'b1;
          out_error_nxt  = 1'b1;
        end else begin
          out_size_nxt   = OSIZE_W'(rd_size);
          out_stride_nxt = rd_stride[OSTRIDE_W-1:0];
          out_last_nxt   = (red_idx_r == '0);
          out_error_nxt  = 1'b0;
        end
        if (err_r || red_idx_r == '0) begin
          rank_cnt_nxt = '0;
          ovf_nxt      = 1'b0;
          err_nxt      = 1'b0;
          state_nxt    = S_IDLE;
        end else begin
          red_idx_nxt = red_idx_r - RED_IDX_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      err_r       <= 1'b0;
      dim_r       <= '0;
      red_cnt_r   <= '0;
      red_idx_r   <= '0;
      mul_step_r  <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      ebits_r     <= EBITS_RESET;
      cum_r       <= 1'b0;
    end else begin
      rank_cnt_r  <= rank_cnt_nxt;
      ovf_r       <= ovf_nxt;
      err_r       <= err_nxt;
      dim_r       <= dim_nxt;
      red_cnt_r   <= red_cnt_nxt;
      red_idx_r   <= red_idx_nxt;
      mul_step_r  <= mul_step_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ELEMENT_BITS:    ebits_r <= cfg_data;
          CFG_CUMULATIVE_MODE: cum_r   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rp_r         <= rp_nxt;
    prev_r       <= prev_nxt;
    ext0_r       <= ext0_nxt;
    acc_r        <= acc_nxt;
    div_q_r      <= div_q_nxt;
    div_rem_r    <= div_rem_nxt;
    out_size_r   <= out_size_nxt;
    out_stride_r <= out_stride_nxt;
    out_last_r   <= out_last_nxt;
    out_error_r  <= out_error_nxt;
  end

  // Dimension store
  always_ff @(posedge clk) begin
    if (dim_we) begin
      size_mem_r[rank_cnt_r[IDX_W-1:0]]   <= in_dim_size;
      stride_mem_r[rank_cnt_r[IDX_W-1:0]] <= in_dim_stride_bits;
    end
  end

  // Reduced store
  always_ff @(posedge clk) begin
    if (red_size_we) begin
      red_size_r[red_waddr] <= red_wsize;
    end
    if (red_stride_we) begin
      red_stride_r[red_waddr] <= red_wstride;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_size         = out_size_r;
  assign out_stride_bytes = out_stride_r;
  assign out_last         = out_last_r;
  assign out_error        = out_error_r;

`ifndef NO_ASSERTIONS
  // A result word only follows a cycle of the emit state
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_EMIT))
    else $error("result word without emit state");

  // The final word leaves the sequencer idle
  a_last_ends_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> state_r == S_IDLE)
    else $error("sequencer still busy after final word");

  // An error word is the only word of its transfer
  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_error_r |=> !out_valid_r)
    else $error("word after error result");

  // A closing dimension word always starts the walk or the error word
  a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_dim |=> busy)
    else $error("closing word did not raise busy");

  // The walk never reaches beyond the stored rank
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RP || state_r == S_CMP) |-> dim_r <= rank_cnt_r)
    else $error("walk position beyond stored rank");
`endif

endmodule

### tb/sv/dma_dimension_coalescer_tb.sv
// Self-checking testbench of the DMA dimension coalescer: directed views, then random phases.
module dma_dimension_coalescer_tb import ddc_pkg::*; ();

  localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] MASK45 = 64'h1FFF_FFFF_FFFF;

  typedef struct packed {
    logic [SIZE_W-1:0]   size;
    logic [STRIDE_W-1:0] stride;
    logic                last;
    logic                drain;   // hold this word back until all results are in
  } dim_word_t;

  typedef struct packed {
    logic [OSIZE_W-1:0]   size;
    logic [OSTRIDE_W-1:0] stride;
    logic                 last;
    logic                 error;
  } red_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  ddc_cfg_idx_t          cfg_index = CFG_ELEMENT_BITS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  start = 1'b0;
  logic [SIZE_W-1:0]     in_dim_size = '0;
  logic [STRIDE_W-1:0]   in_dim_stride_bits = '0;
  logic                  in_last_dim = 1'b0;
  logic                  busy;
  logic                  out_valid;
  logic [OSIZE_W-1:0]    out_size;
  logic [OSTRIDE_W-1:0]  out_stride_bytes;
  logic                  out_last;
  logic                  out_error;

  // Shadow of the configuration and of the dimension store
  logic [EBITS_W-1:0]  elem_bits = EBITS_RESET;
  logic                cum_mode = 1'b0;
  logic [SIZE_W-1:0]   dim_sizes [MAX_RANK];
  logic [STRIDE_W-1:0] dim_strides [MAX_RANK];
  int unsigned         dim_count = 0;
  bit                  dim_overflow = 1'b0;

  dim_word_t   pending_dims[$];
  red_word_t   reduced_due[$];
  int unsigned dims_queued = 0;
  int unsigned n_errors = 0;
  int unsigned gap_left = 0;
  bit          calm = 1'b0;

  dma_dimension_coalescer u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .start              (start),
    .busy               (busy),
    .in_dim_size        (in_dim_size),
    .in_dim_stride_bits (in_dim_stride_bits),
    .in_last_dim        (in_last_dim),
    .out_valid          (out_valid),
    .out_size           (out_size),
    .out_stride_bytes   (out_stride_bytes),
    .out_last           (out_last),
    .out_error          (out_error)
  );

  always #4 clk = ~clk;

  // 48-bit product that saturates; bit 48 flags the overflow
  function automatic logic [48:0] sat_mul(input logic [47:0] a, input logic [47:0] b);
    logic [95:0] p;
    p = a * b;
    if (p > {48'b0, MASK48[47:0]}) return {1'b1, MASK48[47:0]};
    return {1'b0, p[47:0]};
  endfunction

  // Store one dimension word; on the innermost one, walk the view and queue its results
  function automatic void coalesce_dim(input dim_word_t w);
    logic [47:0] red_size [MAX_RANK+1];
    logic [47:0] red_stride [MAX_RANK+1];
    logic [63:0] word_size [MAX_RANK+1];
    logic [63:0] word_stride [MAX_RANK+1];
    logic [47:0] ext0, prod, prev, cs, cst, e;
    logic [95:0] span;
    logic [63:0] rounded, quot, val, sb;
    logic [48:0] mr;
    int unsigned n, m, first, i, k;
    int          d;
    bit          fail;
    red_word_t   r;
    if (dim_count < MAX_RANK) begin
      dim_sizes[dim_count] = w.size;
      dim_strides[dim_count] = w.stride;
      dim_count++;
    end else begin
      dim_overflow = 1'b1;
    end
    if (!w.last) return;

    n = dim_count;
    e = 48'(elem_bits);
    fail = dim_overflow || elem_bits == 0 || n == 0;
    m = 0;
    if (!fail) begin
      mr = sat_mul(48'(dim_sizes[0]), dim_strides[0]);
      fail |= mr[48];
      ext0 = mr[47:0];
      prev = 48'd1;
      prod = 48'd1;
      // walk inner to outer, the element width standing as the innermost size
      for (d = n; d >= 0; d--) begin
        if (d == n) cs = e;
        else cs = 48'(dim_sizes[d]);
        if (d == 0) cst = ext0;
        else cst = dim_strides[d-1];
        mr = sat_mul(prod, cs);
        fail |= mr[48];
        prod = mr[47:0];
        span = prev * cs;
        // cut where the inner span falls short of this stride
        if (span < cst) begin
          if (m < MAX_RANK + 1) begin
            red_size[m] = prod;
            red_stride[m] = cst;
            m++;
          end
          prod = e;
        end
        prev = cst;
      end
      if (prod > e || m == 0) begin
        if (m < MAX_RANK + 1) begin
          red_size[m] = prod;
          red_stride[m] = ext0;
          m++;
        end
      end

      // every stride but the outermost must sit on a byte
      for (i = 0; i + 1 < m; i++)
        if (red_stride[i][2:0] != 3'd0) fail = 1'b1;

      // round to bytes, divide by the element width, reverse to outermost first
      for (i = 0; i < m && !fail; i++) begin
        rounded = (64'(red_size[i]) + 64'd7) & ~64'd7;
        quot = rounded / 64'(e);
        val = (i == 0) ? ((quot * 64'(e) + 64'd7) >> 3) : quot;
        sb = (64'(red_stride[i]) + 64'd7) >> 3;
        if (val > MASK48 || sb > MASK45) fail = 1'b1;
        word_size[m-1-i] = val;
        word_stride[m-1-i] = sb;
      end

      if (!fail && cum_mode && m > 1) begin
        for (k = m - 1; k > 0; k--) begin
          mr = sat_mul(word_size[k-1][47:0], word_size[k][47:0]);
          fail |= mr[48];
          word_size[k-1] = 64'(mr[47:0]);
        end
      end
    end

    dim_count = 0;
    dim_overflow = 1'b0;
    r = '0;
    if (fail) begin
      r.last = 1'b1;
      r.error = 1'b1;
      reduced_due = {reduced_due, r};
      return;
    end
    first = (cum_mode && m > 1) ? 1 : 0;
    for (i = first; i < m; i++) begin
      r.size = word_size[i][OSIZE_W-1:0];
      r.stride = word_stride[i][OSTRIDE_W-1:0];
      r.last = (i + 1 == m);
      r.error = 1'b0;
      reduced_due = {reduced_due, r};
    end
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    n_errors++;
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  // Feed dimension words, predicting each one as it is taken
  always @(posedge clk) begin : feed_dims
    dim_word_t   nxt;
    int unsigned roll;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        coalesce_dim(pending_dims.pop_front());
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) gap_left = 0;
        else if (roll < 92) gap_left = $urandom_range(1, 3);
        else gap_left = $urandom_range(8, 40);
      end
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_dims.size() != 0 &&
                   !(pending_dims[0].drain && (reduced_due.size() != 0 || busy))) begin
        nxt = pending_dims[0];
        start <= 1'b1;
        in_dim_size <= nxt.size;
        in_dim_stride_bits <= nxt.stride;
        in_last_dim <= nxt.last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Check each result word against the oldest prediction
  always @(posedge clk) begin : watch_results
    red_word_t want;
    if (rst_n && out_valid) begin
      if (reduced_due.size() == 0) begin
        report("unexpected word, size", 64'(out_size), 64'd0);
      end else begin
        want = reduced_due.pop_front();
        if (out_size !== want.size) report("out_size", 64'(out_size), 64'(want.size));
        if (out_stride_bytes !== want.stride)
          report("out_stride_bytes", 64'(out_stride_bytes), 64'(want.stride));
        if (out_last !== want.last) report("out_last", 64'(out_last), 64'(want.last));
        if (out_error !== want.error) report("out_error", 64'(out_error), 64'(want.error));
      end
    end
  end

  task automatic add_dim(input logic [31:0] size, input logic [47:0] stride,
                         input bit last, input bit drain = 1'b0);
    dim_word_t w;
    w.size = size;
    w.stride = stride;
    w.last = last;
    w.drain = drain;
    pending_dims = {pending_dims, w};
    dims_queued++;
  endtask

  task automatic write_cfg(input logic [EBITS_W-1:0] ebits, input bit cum);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ELEMENT_BITS;
    cfg_data <= ebits;
    @(posedge clk);
    cfg_index <= CFG_CUMULATIVE_MODE;
    cfg_data <= CFG_DATA_W'(cum);
    @(posedge clk);
    cfg_we <= 1'b0;
    elem_bits = ebits;
    cum_mode = cum;
  endtask

  // Wait until every word is taken and every result is in, then let the block go quiet
  task automatic settle();
    while (pending_dims.size() != 0 || reduced_due.size() != 0 || busy) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Well-formed view: strides grow outward, dense or padded, mostly small sizes
  task automatic gen_view(input int unsigned n, input bit drain);
    logic [31:0] sz [MAX_RANK];
    logic [63:0] st [MAX_RANK];
    logic [63:0] e8;
    int unsigned k;
    int          d;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0:       sz[k] = 32'd0;
        1:       sz[k] = $urandom;
        2, 3:    sz[k] = $urandom_range(17, 4096);
        default: sz[k] = $urandom_range(1, 16);
      endcase
    end
    e8 = (64'(elem_bits) + 64'd7) & ~64'd7;
    case ($urandom_range(0, 3))
      0:       st[n-1] = 64'(elem_bits);
      1, 2:    st[n-1] = e8;
      default: st[n-1] = e8 + 64'(8 * $urandom_range(1, 8));
    endcase
    for (d = n - 1; d > 0; d--) begin
      st[d-1] = ((64'(sz[d]) * st[d] + 64'd7) & ~64'd7) & MASK48;
      if ($urandom_range(0, 3) == 0) st[d-1] += 64'(8 * $urandom_range(1, 16));
    end
    for (k = 0; k < n; k++) add_dim(sz[k], st[k][47:0], k + 1 == n, drain && k == 0);
  endtask

  // Broken view: wild values, unaligned strides, or too many dimensions
  task automatic gen_noise(input bit drain);
    int unsigned n, k;
    logic [31:0] sz;
    logic [47:0] st;
    n = $urandom_range(1, 11);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 2))
        0: begin
          sz = $urandom;
          st = 48'({$urandom, $urandom});
        end
        1: begin
          sz = $urandom_range(1, 16);
          st = 48'(8 * $urandom_range(1, 64) + $urandom_range(1, 7));
        end
        default: begin
          sz = $urandom_range(0, 64);
          st = 48'(8 * $urandom_range(0, 512));
        end
      endcase
      add_dim(sz, st, k + 1 == n, drain && k == 0);
    end
  endtask

  initial begin : stimulus
    int unsigned ph, base, n;
    bit          drain;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration: element width 8, plain sizes
    add_dim(32'd1, 48'd8, 1'b1);
    add_dim(32'd4, 48'd48, 1'b0);
    add_dim(32'd3, 48'd16, 1'b0);
    add_dim(32'd2, 48'd8, 1'b1);
    // padded outer stride forces a cut; hold it until all earlier results are in
    add_dim(32'd2, 48'd64, 1'b0, 1'b1);
    add_dim(32'd5, 48'd8, 1'b1);
    // inner stride off a byte boundary
    add_dim(32'd3, 48'd36, 1'b0);
    add_dim(32'd3, 48'd12, 1'b1);
    // zero size, zero stride, and both fields at their maximum
    add_dim(32'd0, 48'd8, 1'b1);
    add_dim(32'd1, 48'd0, 1'b1);
    add_dim(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
    settle();

    // single-bit elements with suffix products
    write_cfg(7'd1, 1'b1);
    add_dim(32'd6, 48'd48, 1'b0);
    add_dim(32'd3, 48'd16, 1'b0);
    add_dim(32'd2, 48'd8, 1'b1);
    settle();

    // zero element width
    write_cfg(7'd0, 1'b0);
    add_dim(32'd2, 48'd8, 1'b1);
    settle();

    // one dimension more than the store holds
    write_cfg(7'd127, 1'b1);
    for (n = 0; n <= MAX_RANK; n++) add_dim(32'(n + 1), 48'd8, n == MAX_RANK);
    settle();

    // random phases, each under its own configuration
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       write_cfg(7'd64, 1'b0);
        1:       write_cfg(7'd1, 1'b1);
        3:       write_cfg(7'd127, 1'b1);
        default: write_cfg(EBITS_W'($urandom_range(1, 64)), 1'($urandom_range(0, 1)));
      endcase
      calm = (ph == 2);
      base = dims_queued;
      while (dims_queued - base < 15) begin
        drain = ($urandom_range(0, 19) == 0);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(5, MAX_RANK) : $urandom_range(1, 4);
        if ($urandom_range(0, 9) < 7) gen_view(n, drain);
        else gen_noise(drain);
      end
      settle();
    end

    repeat (300) @(posedge clk);
    if (n_errors == 0) begin
      $display("dma_dimension_coalescer test passed");
    end else begin
      $display("dma_dimension_coalescer test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("dma_dimension_coalescer test failed");
    $finish;
  end

endmodule

### files.f
rtl/ddc_pkg.sv
rtl/dma_dimension_coalescer.sv
tb/sv/dma_dimension_coalescer_tb.sv
